[sv/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// Every macro samples on the rising edge of clk and is held off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/rcspb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcspb_pkg
// Shared constants, control types and the microcode program of the stick
// packet builder.
// ----------------------------------------------------------------------------
package rcspb_pkg;

	localparam int PAYLOAD_BYTES = 12;
	localparam int HOP_COUNT     = 3;
	localparam logic [3:0] LAST_IDX = 4'(PAYLOAD_BYTES - 1);
	localparam logic [1:0] HOP_LAST = 2'(HOP_COUNT - 1);

	// Command codes on the op field.
	localparam logic [1:0] OP_TICK       = 2'd0;
	localparam logic [1:0] OP_START_DATA = 2'd1;
	localparam logic [1:0] OP_START_BIND = 2'd2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_STICK_MIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STICK_MAX    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TX_ADDRESS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HOP_CHANNELS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BIND_PACKETS = 3'd4;

	// Register values after reset.
	localparam logic [15:0] RST_STICK_MIN    = 16'hD8F0;
	localparam logic [14:0] RST_STICK_MAX    = 15'd10000;
	localparam logic [39:0] RST_TX_ADDRESS   = 40'd308318750283;
	localparam logic [23:0] RST_HOP_CHANNELS = 24'd1582647;
	localparam logic [15:0] RST_BIND_PACKETS = 16'd250;

	// Payload constants.
	localparam logic [7:0] NEUTRAL_RUDDER = 8'h7a;
	localparam logic [7:0] NEUTRAL_PITCH  = 8'h88;
	localparam logic [7:0] FILLER         = 8'h1e;
	localparam logic [7:0] SEED_BIND      = 8'h3a;
	localparam logic [7:0] SEED_DATA      = 8'h9c;
	localparam logic [7:0] FULL_SCALE     = 8'hff;

	// Divider: one quotient bit per step.
	localparam int DIV_STEPS = 8;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(DIV_STEPS - 1);

	// Program steps.
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] S_IDLE     = 5'd0;
	localparam logic [STEP_W-1:0] S_DISPATCH = 5'd1;
	localparam logic [STEP_W-1:0] S_COMMIT   = 5'd18;
	localparam logic [STEP_W-1:0] S_EMIT     = 5'd19;

	// Sequencer jump conditions.
	localparam logic [2:0] C_NEXT = 3'd0; // fall through
	localparam logic [2:0] C_GO   = 3'd1; // hold until a tick is taken
	localparam logic [2:0] C_BIND = 3'd2; // jump when in bind mode
	localparam logic [2:0] C_LOOP = 3'd3; // repeat while the loop count is nonzero
	localparam logic [2:0] C_EMIT = 3'd4; // hold per byte, jump after the last byte
	localparam logic [2:0] C_JUMP = 3'd5; // jump unconditionally

	// Datapath actions.
	localparam logic [2:0] A_NONE   = 3'd0;
	localparam logic [2:0] A_SETUP  = 3'd1;
	localparam logic [2:0] A_MUL    = 3'd2;
	localparam logic [2:0] A_DIV    = 3'd3;
	localparam logic [2:0] A_STORE  = 3'd4;
	localparam logic [2:0] A_COMMIT = 3'd5;
	localparam logic [2:0] A_EMIT   = 3'd6;

	typedef struct packed {
		logic [2:0]        cond;
		logic [STEP_W-1:0] target;
		logic [2:0]        act;
		logic [1:0]        sel;
		logic              load_cnt;
	} ucode_t;

	typedef struct packed {
		logic       idle;
		logic [2:0] act;
		logic [1:0] sel;
	} ctl_t;

	typedef struct packed {
		logic go;
		logic bind_mode;
		logic out_free;
		logic last_byte;
	} status_t;

	function automatic ucode_t uword(input logic [2:0] cond, input logic [STEP_W-1:0] target,
		input logic [2:0] act, input logic [1:0] sel, input logic load_cnt);
		ucode_t w;
		w.cond     = cond;
		w.target   = target;
		w.act      = act;
		w.sel      = sel;
		w.load_cnt = load_cnt;
		return w;
	endfunction

	// Each stick takes setup, multiply, an eight step divide loop and a store.
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		case (step)
			5'd0:  w = uword(C_GO,   S_IDLE,   A_NONE,   2'd0, 1'b0);
			5'd1:  w = uword(C_BIND, S_COMMIT, A_NONE,   2'd0, 1'b0);
			5'd2:  w = uword(C_NEXT, S_IDLE,   A_SETUP,  2'd0, 1'b0);
			5'd3:  w = uword(C_NEXT, S_IDLE,   A_MUL,    2'd0, 1'b1);
			5'd4:  w = uword(C_LOOP, S_IDLE,   A_DIV,    2'd0, 1'b0);
			5'd5:  w = uword(C_NEXT, S_IDLE,   A_STORE,  2'd0, 1'b0);
			5'd6:  w = uword(C_NEXT, S_IDLE,   A_SETUP,  2'd1, 1'b0);
			5'd7:  w = uword(C_NEXT, S_IDLE,   A_MUL,    2'd1, 1'b1);
			5'd8:  w = uword(C_LOOP, S_IDLE,   A_DIV,    2'd1, 1'b0);
			5'd9:  w = uword(C_NEXT, S_IDLE,   A_STORE,  2'd1, 1'b0);
			5'd10: w = uword(C_NEXT, S_IDLE,   A_SETUP,  2'd2, 1'b0);
			5'd11: w = uword(C_NEXT, S_IDLE,   A_MUL,    2'd2, 1'b1);
			5'd12: w = uword(C_LOOP, S_IDLE,   A_DIV,    2'd2, 1'b0);
			5'd13: w = uword(C_NEXT, S_IDLE,   A_STORE,  2'd2, 1'b0);
			5'd14: w = uword(C_NEXT, S_IDLE,   A_SETUP,  2'd3, 1'b0);
			5'd15: w = uword(C_NEXT, S_IDLE,   A_MUL,    2'd3, 1'b1);
			5'd16: w = uword(C_LOOP, S_IDLE,   A_DIV,    2'd3, 1'b0);
			5'd17: w = uword(C_NEXT, S_IDLE,   A_STORE,  2'd3, 1'b0);
			5'd18: w = uword(C_NEXT, S_IDLE,   A_COMMIT, 2'd0, 1'b0);
			5'd19: w = uword(C_EMIT, S_IDLE,   A_EMIT,   2'd0, 1'b0);
			default: w = uword(C_JUMP, S_IDLE, A_NONE,   2'd0, 1'b0);
		endcase
		return w;
	endfunction

endpackage

[sv/rcspb_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcspb_seq
// Microcode sequencer: step counter, program table lookup, loop counter
// and conditional jumps.
// ----------------------------------------------------------------------------
module rcspb_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  rcspb_pkg::status_t status,
	output rcspb_pkg::ctl_t    ctl
);

	logic [rcspb_pkg::STEP_W-1:0] step_q;
	logic [rcspb_pkg::STEP_W-1:0] step_d;
	logic [rcspb_pkg::STEP_W-1:0] step_inc;
	logic [rcspb_pkg::CNT_W-1:0]  cnt_q;
	rcspb_pkg::ucode_t            word;

	assign word     = rcspb_pkg::ucode_rom(step_q);
	assign step_inc = step_q + rcspb_pkg::STEP_W'(1);

	always_comb begin
		case (word.cond)
			rcspb_pkg::C_NEXT: step_d = step_inc;
			rcspb_pkg::C_GO:   step_d = status.go ? step_inc : step_q;
			rcspb_pkg::C_BIND: step_d = status.bind_mode ? word.target : step_inc;
			rcspb_pkg::C_LOOP: step_d = (cnt_q != '0) ? step_q : step_inc;
			rcspb_pkg::C_EMIT: step_d = (status.out_free && status.last_byte) ? word.target : step_q;
			rcspb_pkg::C_JUMP: step_d = word.target;
			default:           step_d = rcspb_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= rcspb_pkg::S_IDLE;
			cnt_q  <= '0;
		end else begin
			step_q <= step_d;
			if (word.load_cnt) begin
				cnt_q <= rcspb_pkg::CNT_LOAD;
			end else if (word.cond == rcspb_pkg::C_LOOP && cnt_q != '0) begin
				cnt_q <= cnt_q - rcspb_pkg::CNT_W'(1);
			end
		end
	end

	assign ctl.idle = (step_q == rcspb_pkg::S_IDLE);
	assign ctl.act  = word.act;
	assign ctl.sel  = word.sel;

endmodule

[sv/rcspb_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcspb_scale
// Stick scaling datapath: clamp and span selection, one multiplier and a
// restoring divider that yields one quotient bit per step.
// ----------------------------------------------------------------------------
module rcspb_scale (
	input  logic               clk,
	input  rcspb_pkg::ctl_t    ctl,
	input  logic signed [15:0] stick [4],
	input  logic signed [15:0] lo,
	input  logic [14:0]        hi,
	output logic [7:0]         result
);

	logic signed [16:0] v;
	logic signed [16:0] lo_x;
	logic signed [16:0] hi_x;
	logic signed [16:0] vc;
	logic signed [16:0] diff;
	logic signed [16:0] den;
	logic [7:0]         mid;
	logic [7:0]         factor;
	logic [7:0]         off;

	logic [15:0] diff_q;
	logic [15:0] den_q;
	logic [7:0]  factor_q;
	logic [7:0]  off_q;
	logic [23:0] rem_q;
	logic [23:0] den_sh_q;
	logic [7:0]  quo_q;
	logic        ge;

	assign v    = {stick[ctl.sel][15], stick[ctl.sel]};
	assign lo_x = {lo[15], lo};
	assign hi_x = {2'b00, hi};
	assign mid  = (ctl.sel == 2'd1) ? rcspb_pkg::NEUTRAL_RUDDER : rcspb_pkg::NEUTRAL_PITCH;

	// Throttle spans the whole range; the other sticks split at zero around a neutral.
	always_comb begin
		if (ctl.sel == 2'd0) begin
			vc     = (v < lo_x) ? lo_x : ((v > hi_x) ? hi_x : v);
			diff   = vc - lo_x;
			den    = hi_x - lo_x;
			factor = rcspb_pkg::FULL_SCALE;
			off    = 8'd0;
		end else if (v <= 17'sd0) begin
			vc     = (v < lo_x) ? lo_x : v;
			diff   = vc - lo_x;
			den    = -lo_x;
			factor = mid;
			off    = 8'd0;
		end else begin
			vc     = (v > hi_x) ? hi_x : v;
			diff   = vc;
			den    = hi_x;
			factor = rcspb_pkg::FULL_SCALE - mid;
			off    = mid;
		end
	end

	assign ge = (rem_q >= den_sh_q);

	// The product never exceeds 255 times the span, so eight quotient bits suffice.
	always_ff @(posedge clk) begin
		case (ctl.act)
			rcspb_pkg::A_SETUP: begin
				diff_q   <= diff[15:0];
				den_q    <= den[15:0];
				factor_q <= factor;
				off_q    <= off;
			end
			rcspb_pkg::A_MUL: begin
				rem_q    <= {16'd0, factor_q} * {8'd0, diff_q};
				den_sh_q <= {1'b0, den_q, 7'd0};
				quo_q    <= 8'd0;
			end
			rcspb_pkg::A_DIV: begin
				rem_q    <= ge ? (rem_q - den_sh_q) : rem_q;
				den_sh_q <= den_sh_q >> 1;
				quo_q    <= {quo_q[6:0], ge};
			end
			default: begin
			end
		endcase
	end

	assign result = quo_q + off_q;

endmodule

[sv/rc_stick_packet_builder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_stick_packet_builder
// Builds one 12-byte radio-control payload per tick and streams it out a
// byte at a time.
// ----------------------------------------------------------------------------
// Usage:
// The command channel (cmd_valid/cmd_stall) carries op and the four stick
// values. A tick (op 0) yields twelve byte transfers on the byte channel
// (byte_valid/byte_stall), with last on byte 11. Ops 1 and 2 restart the hop
// sequence in data or bind mode and yield nothing; op 3 is ignored.
// Registers are written over cfg_valid/cfg_ready/cfg_index/cfg_data; the user
// must write them only while no packet is in flight, which the block itself
// does not enforce; cfg_ready is always high. A data tick runs setup,
// multiply, eight divide steps and a store for each of the four sticks,
// then commits the packet and emits its bytes. A bind tick skips the
// scaling and goes straight from dispatch to the commit.
// The command channel stalls while a packet is being built or sent.
// A stall on the byte channel holds the current byte and pauses the
// sequencer, so no byte is lost. Reset restores the register defaults,
// enters data mode and clears the hop index and packet counter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rc_stick_packet_builder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  logic [1:0]                          op,
	input  logic signed [15:0]                  throttle,
	input  logic signed [15:0]                  rudder,
	input  logic signed [15:0]                  elevator,
	input  logic signed [15:0]                  aileron,
	output logic                                byte_valid,
	input  logic                                byte_stall,
	output logic [7:0]                          payload_byte,
	output logic [3:0]                          byte_index,
	output logic                                last,
	output logic [7:0]                          rf_channel,
	output logic                                channel_change,
	output logic                                is_bind,
	output logic                                bind_finished,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rcspb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [39:0]                         cfg_data
);

	rcspb_pkg::ctl_t    ctl;
	rcspb_pkg::status_t status;

	logic [15:0] stick_min_q;
	logic [14:0] stick_max_q;
	logic [39:0] tx_address_q;
	logic [23:0] hop_channels_q;
	logic [15:0] bind_packets_q;

	logic        in_bind_q;
	logic [15:0] bind_remaining_q;
	logic [1:0]  hop_index_q;
	logic [7:0]  packet_count_q;

	logic signed [15:0] stick_q [4];
	logic [7:0]         pkt_q [4];
	logic [7:0]         count_byte_q;
	logic               pkt_bind_q;
	logic               pkt_fin_q;
	logic [7:0]         pkt_rf_q;
	logic [7:0]         sum_q;
	logic [3:0]         idx_q;

	logic               byte_valid_q;
	logic [7:0]         payload_byte_q;
	logic [3:0]         byte_index_q;
	logic               last_q;
	logic [7:0]         rf_channel_q;
	logic               channel_change_q;
	logic               is_bind_q;
	logic               bind_finished_q;

	logic               cmd_take;
	logic signed [15:0] lo_eff;
	logic [14:0]        hi_eff;
	logic [7:0]         scaled;
	logic [1:0]         hop_k;
	logic [7:0]         hop_sel;
	logic [15:0]        bind_dec;
	logic [7:0]         asm_byte;
	logic [7:0]         out_byte;
	logic               emit_fire;

	assign cmd_stall = !ctl.idle;
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign cfg_ready = 1'b1;

	assign status.go        = cmd_take && (op == rcspb_pkg::OP_TICK);
	assign status.bind_mode = in_bind_q;
	assign status.out_free  = !byte_valid_q || !byte_stall;
	assign status.last_byte = (idx_q == rcspb_pkg::LAST_IDX);

	assign emit_fire = (ctl.act == rcspb_pkg::A_EMIT) && status.out_free;

	rcspb_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctl    (ctl)
	);

	// A non-negative minimum acts as -1 and a zero maximum as 1.
	assign lo_eff = stick_min_q[15] ? $signed(stick_min_q) : -16'sd1;
	assign hi_eff = (stick_max_q == 15'd0) ? 15'd1 : stick_max_q;

	rcspb_scale u_scale (
		.clk    (clk),
		.ctl    (ctl),
		.stick  (stick_q),
		.lo     (lo_eff),
		.hi     (hi_eff),
		.result (scaled)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stick_min_q    <= rcspb_pkg::RST_STICK_MIN;
			stick_max_q    <= rcspb_pkg::RST_STICK_MAX;
			tx_address_q   <= rcspb_pkg::RST_TX_ADDRESS;
			hop_channels_q <= rcspb_pkg::RST_HOP_CHANNELS;
			bind_packets_q <= rcspb_pkg::RST_BIND_PACKETS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rcspb_pkg::CFG_STICK_MIN:    stick_min_q    <= cfg_data[15:0];
				rcspb_pkg::CFG_STICK_MAX:    stick_max_q    <= cfg_data[14:0];
				rcspb_pkg::CFG_TX_ADDRESS:   tx_address_q   <= cfg_data;
				rcspb_pkg::CFG_HOP_CHANNELS: hop_channels_q <= cfg_data[23:0];
				rcspb_pkg::CFG_BIND_PACKETS: bind_packets_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Hop selection; an index past the table restarts at table entry 0.
	assign hop_k = (hop_index_q > rcspb_pkg::HOP_LAST) ? 2'd0 : hop_index_q;

	always_comb begin
		case (hop_k)
			2'd0:    hop_sel = hop_channels_q[23:16];
			2'd1:    hop_sel = hop_channels_q[15:8];
			2'd2:    hop_sel = hop_channels_q[7:0];
			default: hop_sel = hop_channels_q[23:16];
		endcase
	end

	assign bind_dec = bind_remaining_q - 16'd1;

	// Mode and counter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_bind_q        <= 1'b0;
			bind_remaining_q <= 16'd0;
			hop_index_q      <= 2'd0;
			packet_count_q   <= 8'd0;
		end else if (cmd_take && op == rcspb_pkg::OP_START_DATA) begin
			hop_index_q <= 2'd0;
			in_bind_q   <= 1'b0;
		end else if (cmd_take && op == rcspb_pkg::OP_START_BIND) begin
			hop_index_q      <= 2'd0;
			in_bind_q        <= 1'b1;
			bind_remaining_q <= bind_packets_q;
		end else if (ctl.act == rcspb_pkg::A_COMMIT) begin
			if (in_bind_q) begin
				bind_remaining_q <= bind_dec;
				if (bind_dec == 16'd0) begin
					in_bind_q <= 1'b0;
				end
			end else begin
				packet_count_q <= packet_count_q + 8'd1;
				hop_index_q    <= (hop_k == rcspb_pkg::HOP_LAST) ? 2'd0 : hop_k + 2'd1;
			end
		end
	end

	// Packet working registers.
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			stick_q[0] <= throttle;
			stick_q[1] <= rudder;
			stick_q[2] <= elevator;
			stick_q[3] <= aileron;
		end
		if (ctl.act == rcspb_pkg::A_STORE) begin
			pkt_q[ctl.sel] <= scaled;
		end
		if (ctl.act == rcspb_pkg::A_COMMIT) begin
			pkt_bind_q   <= in_bind_q;
			pkt_fin_q    <= in_bind_q && (bind_dec == 16'd0);
			pkt_rf_q     <= in_bind_q ? 8'd0 : (hop_sel + {hop_sel[6:0], 1'b0});
			count_byte_q <= packet_count_q;
			sum_q        <= in_bind_q ? rcspb_pkg::SEED_BIND : rcspb_pkg::SEED_DATA;
			idx_q        <= 4'd0;
		end else if (emit_fire) begin
			sum_q <= sum_q + asm_byte;
			idx_q <= idx_q + 4'd1;
		end
	end

	// Payload byte at the current position; the checksum slot is taken from sum_q.
	always_comb begin
		if (pkt_bind_q) begin
			case (idx_q)
				4'd0:    asm_byte = tx_address_q[39:32];
				4'd1:    asm_byte = tx_address_q[31:24];
				4'd2:    asm_byte = tx_address_q[23:16];
				4'd3:    asm_byte = tx_address_q[15:8];
				4'd4:    asm_byte = hop_channels_q[23:16];
				4'd5:    asm_byte = hop_channels_q[15:8];
				4'd6:    asm_byte = hop_channels_q[7:0];
				4'd7:    asm_byte = rcspb_pkg::FILLER;
				4'd10:   asm_byte = tx_address_q[7:0];
				default: asm_byte = 8'd0;
			endcase
		end else begin
			case (idx_q)
				4'd0, 4'd1, 4'd2, 4'd3: asm_byte = pkt_q[idx_q[1:0]];
				4'd4, 4'd5, 4'd6, 4'd7: asm_byte = rcspb_pkg::FILLER;
				4'd10:   asm_byte = count_byte_q;
				default: asm_byte = 8'd0;
			endcase
		end
	end

	assign out_byte = (idx_q == rcspb_pkg::LAST_IDX) ? sum_q : asm_byte;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_q <= 1'b0;
		end else if (emit_fire) begin
			byte_valid_q <= 1'b1;
		end else if (!byte_stall) begin
			byte_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			payload_byte_q   <= out_byte;
			byte_index_q     <= idx_q;
			last_q           <= (idx_q == rcspb_pkg::LAST_IDX);
			rf_channel_q     <= pkt_rf_q;
			channel_change_q <= !pkt_bind_q;
			is_bind_q        <= pkt_bind_q;
			bind_finished_q  <= pkt_fin_q;
		end
	end

	assign byte_valid     = byte_valid_q;
	assign payload_byte   = payload_byte_q;
	assign byte_index     = byte_index_q;
	assign last           = last_q;
	assign rf_channel     = rf_channel_q;
	assign channel_change = channel_change_q;
	assign is_bind        = is_bind_q;
	assign bind_finished  = bind_finished_q;

	`ASSERT_NEXT(a_tick_busy, cmd_valid && !cmd_stall && op == rcspb_pkg::OP_TICK, cmd_stall, "tick transfer did not start a packet")
	`ASSERT_NEXT(a_bytes_contiguous, byte_valid && !byte_stall && !last, byte_valid, "gap inside a packet")
	`ASSERT_IMPLIES(a_bind_no_hop, byte_valid && is_bind, !channel_change && rf_channel == 8'd0, "bind packet carries a channel change")
	`ASSERT_IMPLIES(a_finish_in_bind, byte_valid && bind_finished, is_bind, "bind end flagged on a data packet")

endmodule
